// ===== design/pdh_pkg.sv =====
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared widths, constants, operation codes and the control bundle that the
// sequencer passes to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package pdh_pkg;

    localparam int DATA_W             = 32;
    localparam int ACC_W              = 64;
    localparam int FRAC_W             = 16;
    localparam int DEG_W              = 4;
    localparam int IDX_W              = 4;
    localparam int MAX_DEGREE_DEFAULT = 15;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic load_x;
        logic clear;
        logic first;
        logic abs_step;
        logic mul_lo;
        logic mul_hi;
        logic norm_step;
        logic add_step;
    } mac_ctrl_t;

endpackage

// ===== design/pdh_coeff_mem.sv =====
// ----------------------------------------------------------------------------
// pdh_coeff_mem
// Coefficient memory with one write port and one registered read port. Each
// entry has a valid bit that reset clears; an entry not yet written reads as
// zero.
// ----------------------------------------------------------------------------
module pdh_coeff_mem
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [pdh_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [pdh_pkg::DATA_W-1:0] rd_data
);
    import pdh_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]         valid_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pdh_mac.sv =====
// ----------------------------------------------------------------------------
// pdh_mac
// Horner datapath: forms k * a[k], multiplies the accumulator by x through
// one shared 32 by 32 multiplier in two halves, rescales, and adds with
// saturation. Also gives the final 32-bit clamp and overflow flag.
// ----------------------------------------------------------------------------
module pdh_mac
#(
    parameter int K_W = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdh_pkg::mac_ctrl_t                ctrl,
    input  logic signed [pdh_pkg::DATA_W-1:0] point_x,
    input  logic [K_W-1:0]                    k,
    input  logic signed [pdh_pkg::DATA_W-1:0] coeff,
    output logic signed [pdh_pkg::DATA_W-1:0] result,
    output logic                              result_sat
);
    import pdh_pkg::*;

    localparam int TERM_W = DATA_W + K_W + 1;
    localparam logic signed [ACC_W:0] LIM_P = (ACC_W+1)'(ACC_LIMIT);
    localparam logic signed [ACC_W:0] LIM_N = -LIM_P;

    logic [DATA_W-1:0]        x_mag_reg;
    logic                     x_neg_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-2:0]         acc_mag_reg;
    logic                     acc_neg_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic [ACC_W-1:0]         lo_reg;
    logic [ACC_W-1:0]         hi_reg;
    logic [ACC_W-2:0]         mag_reg;
    logic                     prod_neg_reg;
    logic                     sat_reg;

    logic signed [TERM_W-1:0] kprod;
    logic [DATA_W-1:0]        mul_a;
    logic [ACC_W-1:0]         mul_p;
    logic                     hi_ovf;
    logic [ACC_W-1:0]         mag_sum;
    logic                     norm_sat;
    logic signed [ACC_W:0]    term_ext;
    logic signed [ACC_W:0]    mag_ext;
    logic signed [ACC_W:0]    sum;
    logic                     add_sat_p;
    logic                     add_sat_n;
    logic                     out_hi;
    logic                     out_lo;

    assign kprod = TERM_W'($signed({1'b0, k})) * TERM_W'(coeff);

    assign mul_a = ctrl.mul_hi ? DATA_W'(acc_mag_reg[ACC_W-2:DATA_W])
                               : acc_mag_reg[DATA_W-1:0];
    assign mul_p = ACC_W'(mul_a) * ACC_W'(x_mag_reg);

    assign hi_ovf   = |hi_reg[ACC_W-1:ACC_W-1-FRAC_W];
    assign mag_sum  = ACC_W'({hi_reg[ACC_W-2-FRAC_W:0], {FRAC_W{1'b0}}})
                    + ACC_W'(lo_reg[ACC_W-1:FRAC_W]);
    assign norm_sat = hi_ovf || mag_sum[ACC_W-1];

    assign term_ext  = (ACC_W+1)'(term_reg);
    assign mag_ext   = $signed({2'b00, mag_reg});
    assign sum       = prod_neg_reg ? (term_ext - mag_ext) : (term_ext + mag_ext);
    assign add_sat_p = sum > LIM_P;
    assign add_sat_n = sum < LIM_N;

    assign out_hi = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:DATA_W-1]);
    assign out_lo = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:DATA_W-1]);

    always_comb
    begin
        if (out_hi)
        begin
            result = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (out_lo)
        begin
            result = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            result = acc_reg[DATA_W-1:0];
        end
    end

    assign result_sat = sat_reg || out_hi || out_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctrl.clear || ctrl.first)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctrl.norm_step && norm_sat)
        begin
            sat_reg <= 1'b1;
        end
        else if (ctrl.add_step && (add_sat_p || add_sat_n))
        begin
            sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
        begin
            x_neg_reg <= point_x[DATA_W-1];
            x_mag_reg <= point_x[DATA_W-1] ? (~point_x + 1'b1) : point_x;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.first)
        begin
            acc_reg <= ACC_W'(kprod);
        end
        else if (ctrl.add_step)
        begin
            if (add_sat_p)
            begin
                acc_reg <= ACC_LIMIT;
            end
            else if (add_sat_n)
            begin
                acc_reg <= -ACC_LIMIT;
            end
            else
            begin
                acc_reg <= ACC_W'(sum);
            end
        end
        if (ctrl.abs_step)
        begin
            acc_neg_reg <= acc_reg[ACC_W-1];
            acc_mag_reg <= acc_reg[ACC_W-1] ? (ACC_W-1)'(-acc_reg)
                                            : acc_reg[ACC_W-2:0];
            term_reg    <= kprod;
        end
        if (ctrl.mul_lo)
        begin
            lo_reg <= mul_p;
        end
        if (ctrl.mul_hi)
        begin
            hi_reg <= mul_p;
        end
        if (ctrl.norm_step)
        begin
            mag_reg      <= norm_sat ? ACC_LIMIT[ACC_W-2:0] : mag_sum[ACC_W-2:0];
            prod_neg_reg <= acc_neg_reg ^ x_neg_reg;
        end
    end

endmodule

// ===== design/polynomial_derivative_horner_unit.sv =====
// ----------------------------------------------------------------------------
// polynomial_derivative_horner_unit
// Evaluates the first derivative of a stored polynomial at a point by
// Horner's method in signed Q16.16, with a saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
// A write item stores a coefficient and leaves the block free for the next
// item; an evaluate item keeps the block busy from acceptance until its
// result enters the output register, since each coefficient below the
// leading one, down to a[1], passes through five steps around a single
// shared 32 by 32 multiplier that forms the accumulator-times-x product in
// two halves, with the coefficient memory read in the step before. The result
// waits in an output register, so a finished evaluation never holds up the
// input once that register is free. The coefficient store clears instantly
// at reset by per-entry valid bits, and no clearing sweep is needed.
module polynomial_derivative_horner_unit
#(
    parameter int MAX_DEGREE = pdh_pkg::MAX_DEGREE_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [pdh_pkg::DEG_W-1:0]         cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [pdh_pkg::IDX_W-1:0]         coeff_index,
    input  logic signed [pdh_pkg::DATA_W-1:0] coeff_value,
    input  logic signed [pdh_pkg::DATA_W-1:0] point_x,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pdh_pkg::DATA_W-1:0] derivative,
    output logic                              overflow
);
    import pdh_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = (IW > DEG_W) ? IW : DEG_W;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ,
        ST_FIRST,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_NORM,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [IW-1:0]            k_reg;
    logic [IW-1:0]            k_next;
    logic [DEG_W-1:0]         poly_degree_reg;
    logic [DEG_W-1:0]         poly_degree_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] derivative_reg;
    logic signed [DATA_W-1:0] derivative_next;
    logic                     overflow_reg;
    logic                     overflow_next;

    logic                     in_accept;
    logic                     is_eval;
    logic                     idx_ok;
    logic [CW-1:0]            deg_wide;
    logic [CW-1:0]            deg_eff;
    logic                     out_free;
    logic                     k_last;
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    mac_ctrl_t                ctrl;
    logic signed [DATA_W-1:0] result;
    logic                     result_sat;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign is_eval   = op == OP_EVAL;
    assign idx_ok    = CW'(coeff_index) <= CW'(MAX_DEGREE);
    assign deg_wide  = CW'(poly_degree_reg);
    assign deg_eff   = (deg_wide > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : deg_wide;
    assign out_free  = !out_valid_reg || !out_stall;
    assign k_last    = k_reg == IW'(1);

    assign wr_en   = in_accept && !is_eval && idx_ok;
    assign wr_addr = IW'(coeff_index);

    assign out_valid  = out_valid_reg;
    assign derivative = derivative_reg;
    assign overflow   = overflow_reg;

    pdh_coeff_mem
    #(
        .DEPTH  (DEPTH),
        .ADDR_W (IW)
    )
    u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (coeff_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pdh_mac
    #(
        .K_W (IW)
    )
    u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .point_x    (point_x),
        .k          (k_reg),
        .coeff      (rd_data),
        .result     (result),
        .result_sat (result_sat)
    );

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        poly_degree_next = cfg_write_en ? cfg_write_data : poly_degree_reg;
        out_valid_next   = out_valid_reg && out_stall;
        derivative_next  = derivative_reg;
        overflow_next    = overflow_reg;
        rd_en            = 1'b0;
        rd_addr          = k_reg;
        ctrl             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && is_eval)
                begin
                    ctrl.load_x = 1'b1;
                    if (deg_eff == '0)
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        k_next     = IW'(deg_eff);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST, ST_ADD:
            begin
                ctrl.first    = state_reg == ST_FIRST;
                ctrl.add_step = state_reg == ST_ADD;
                if (k_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - 1'b1;
                    k_next     = k_reg - 1'b1;
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                ctrl.abs_step = 1'b1;
                state_next    = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                ctrl.mul_lo = 1'b1;
                state_next  = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                ctrl.mul_hi = 1'b1;
                state_next  = ST_NORM;
            end
            ST_NORM:
            begin
                ctrl.norm_step = 1'b1;
                state_next     = ST_ADD;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    derivative_next = result;
                    overflow_next   = result_sat;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            poly_degree_reg <= '0;
            out_valid_reg   <= 1'b0;
            derivative_reg  <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            poly_degree_reg <= poly_degree_next;
            out_valid_reg   <= out_valid_next;
            derivative_reg  <= derivative_next;
            overflow_reg    <= overflow_next;
        end
    end

    // The loop counter never reaches zero while coefficients are being used.
    a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_FIRST || state_reg == ST_ABS ||
         state_reg == ST_MUL_LO || state_reg == ST_MUL_HI ||
         state_reg == ST_NORM || state_reg == ST_ADD) |-> k_reg != '0)
        else $error("Loop counter is zero during an evaluation.");

    // A coefficient write never coincides with an evaluation read.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("Coefficient write and read in the same cycle.");

    // A degree-zero evaluation goes through the finish state to the output.
    a_deg0_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_eval && deg_eff == '0 && !out_valid_reg) |=> ##1 out_valid)
        else $error("Degree-zero item did not complete in time.");

endmodule

// ===== sim/tb_polynomial_derivative_horner_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polynomial_derivative_horner_unit
// Loads coefficients into the block, sets the degree, and evaluates the
// derivative at many points. Random gaps and stalls fall on both channels.
// A local fixed-point Horner predictor supplies the expected value and the
// saturation flag of every evaluate item, and each result is compared with
// the oldest one that is still waiting.
// ----------------------------------------------------------------------------
module tb_polynomial_derivative_horner_unit;

    import pdh_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

    typedef struct
    {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } deriv_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write_en;
    logic [DEG_W-1:0]         cfg_write_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     op;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point_x;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] derivative;
    logic                     overflow;

    logic signed [DATA_W-1:0] coeff_mem [0:15];
    logic [DEG_W-1:0]         degree_reg;
    deriv_result_t            pending_derivs [$];
    int                       mismatch_count;
    int                       stuck_cycles;
    bit                       no_idle;

    polynomial_derivative_horner_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .coeff_index    (coeff_index),
        .coeff_value    (coeff_value),
        .point_x        (point_x),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .derivative     (derivative),
        .overflow       (overflow)
    );

    always #4 clk = ~clk;

    function automatic int idle_cycles();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic signed [63:0] scale_by_x(input logic signed [63:0] acc,
                                                      input logic signed [31:0] x,
                                                      inout logic sat);
        logic         neg;
        logic [63:0]  am;
        logic [31:0]  xm;
        logic [127:0] mag;
        logic signed [63:0] r;
        neg = (acc < 0) != (x < 0);
        am  = (acc < 0) ? -acc : acc;
        xm  = (x < 0) ? -x : x;
        mag = ({64'd0, am} * {96'd0, xm}) >> FRAC_W;
        if (mag > {64'd0, ACC_LIMIT})
        begin
            sat = 1'b1;
            r   = ACC_LIMIT;
        end
        else
        begin
            r = mag[63:0];
        end
        return neg ? -r : r;
    endfunction

    function automatic logic signed [63:0] add_clamped(input logic signed [63:0] acc,
                                                       input logic signed [63:0] term,
                                                       inout logic sat);
        logic signed [64:0] s;
        s = acc + term;
        if (s > ACC_LIMIT)
        begin
            sat = 1'b1;
            return ACC_LIMIT;
        end
        if (s < -ACC_LIMIT)
        begin
            sat = 1'b1;
            return -ACC_LIMIT;
        end
        return s[63:0];
    endfunction

    function automatic deriv_result_t horner_derivative(input logic signed [31:0] x);
        deriv_result_t      res;
        logic signed [63:0] acc;
        logic signed [63:0] term;
        logic               sat;
        int                 deg;
        sat = 1'b0;
        deg = degree_reg;
        acc = '0;
        if (deg != 0)
        begin
            acc = coeff_mem[deg];
            acc = acc * deg;
            for (int k = deg - 1; k >= 1; k--)
            begin
                acc  = scale_by_x(acc, x, sat);
                term = coeff_mem[k];
                term = term * k;
                acc  = add_clamped(acc, term, sat);
            end
        end
        if (acc > OUT_MAX)
        begin
            acc = OUT_MAX;
            sat = 1'b1;
        end
        else if (acc < OUT_MIN)
        begin
            acc = OUT_MIN;
            sat = 1'b1;
        end
        res.value = acc[31:0];
        res.sat   = sat;
        return res;
    endfunction

    function automatic logic signed [31:0] pick_coeff();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sh00010000;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_point();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return $urandom;
            3:       return 32'sh00000000;
            default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    // Entered at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input op_t kind, input logic [3:0] idx,
                             input logic signed [31:0] value, input logic signed [31:0] x);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        coeff_index <= idx;
        coeff_value <= value;
        point_x     <= x;
        do @(posedge clk); while (in_stall);
        if (kind == OP_WRITE)
        begin
            coeff_mem[idx] = value;
        end
        else
        begin
            pending_derivs.push_back(horner_derivative(x));
        end
        @(negedge clk);
    endtask

    task automatic write_coeff(input logic [3:0] idx, input logic signed [31:0] value);
        send_item(OP_WRITE, idx, value, $urandom);
    endtask

    task automatic evaluate_at(input logic signed [31:0] x);
        send_item(OP_EVAL, 4'($urandom_range(0, 15)), $urandom, x);
    endtask

    task automatic set_degree(input logic [3:0] deg);
        in_valid <= 1'b0;
        while (pending_derivs.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= deg;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        degree_reg = deg;
    endtask

    task automatic test_cleared_store();
        set_degree(4'd15);
        evaluate_at(32'sh7FFFFFFF);
        evaluate_at(32'sh80000000);
    endtask

    task automatic test_low_degrees();
        set_degree(4'd0);
        write_coeff(4'd0, 32'sh80000000);
        write_coeff(4'd1, 32'sh7FFFFFFF);
        evaluate_at(32'sh7FFFFFFF);
        set_degree(4'd1);
        evaluate_at(32'sh80000000);
        write_coeff(4'd1, 32'sh80000000);
        evaluate_at(32'sh00010000);
    endtask

    task automatic test_saturation();
        set_degree(4'd15);
        for (int k = 2; k <= 15; k++)
        begin
            write_coeff(k[3:0], k[0] ? 32'sh80000000 : 32'sh7FFFFFFF);
        end
        evaluate_at(32'sh7FFFFFFF);
        evaluate_at(32'shFFFFFFFF);
        evaluate_at(32'sh00010000);
    endtask

    task automatic test_random_phases();
        int phase;
        int issued;
        int deg;
        phase  = 0;
        issued = 0;
        while (issued < 550)
        begin
            case (phase)
                0:       deg = 15;
                1:       deg = 0;
                2:       deg = 1;
                3:       deg = 15;
                default: deg = $urandom_range(0, 15);
            endcase
            no_idle = (phase % 4 == 2);
            set_degree(deg[3:0]);
            for (int k = 0; k <= deg; k++)
            begin
                write_coeff(k[3:0], pick_coeff());
            end
            repeat (30)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    evaluate_at(pick_point());
                end
                else
                begin
                    write_coeff(4'($urandom_range(0, 15)), pick_coeff());
                end
            end
            issued += deg + 31;
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            deriv_result_t want;
            int            hold;
            hold = idle_cycles();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_derivs.size() == 0)
            begin
                $display("%0t unexpected result: derivative %h overflow %b",
                         $time, derivative, overflow);
                mismatch_count++;
            end
            else
            begin
                want = pending_derivs.pop_front();
                if (derivative !== want.value)
                begin
                    $display("%0t derivative mismatch: expected %h, actual %h",
                             $time, want.value, derivative);
                    mismatch_count++;
                end
                if (overflow !== want.sat)
                begin
                    $display("%0t overflow mismatch: expected %b, actual %b",
                             $time, want.sat, overflow);
                    mismatch_count++;
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        op             = OP_WRITE;
        coeff_index    = '0;
        coeff_value    = '0;
        point_x        = '0;
        degree_reg     = '0;
        no_idle        = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            coeff_mem[k] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_cleared_store();
        test_low_degrees();
        test_saturation();
        test_random_phases();

        in_valid <= 1'b0;
        while (pending_derivs.size() != 0) @(negedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
